### design/bdasc_pkg.sv
// ----------------------------------------------------------------------------
// bdasc_pkg
// Shared types, constants and the control store of the binary to decimal
// ASCII converter.
// ----------------------------------------------------------------------------
package bdasc_pkg;

    localparam int DEF_VALUE_BITS = 32;
    localparam int DEF_MAX_DIGITS = 10;
    localparam int CHAR_W         = 6;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] ASCII_NINE = CHAR_W'(57);

    typedef logic [1:0] t_pc;

    localparam t_pc STEP_IDLE = 2'd0;
    localparam t_pc STEP_DAB  = 2'd1;
    localparam t_pc STEP_SKIP = 2'd2;
    localparam t_pc STEP_EMIT = 2'd3;

    typedef enum logic [1:0] {
        OP_IDLE = 2'd0,
        OP_DAB  = 2'd1,
        OP_SKIP = 2'd2,
        OP_EMIT = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        C_NO_IN     = 2'd0,
        C_MORE_BITS = 2'd1,
        C_SKIP_ZERO = 2'd2,
        C_NOT_DONE  = 2'd3
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        t_op op;
    } t_ctrl;

    typedef struct packed {
        logic in_fire;
        logic more_bits;
        logic skip_zero;
        logic emit_last;
    } t_status;

    // control store: jump to target when cond holds, else fall through
    function automatic t_uword urom(input t_pc pc);
        t_uword w;
        case (pc)
            STEP_IDLE: w = '{op: OP_IDLE, cond: C_NO_IN,     target: STEP_IDLE};
            STEP_DAB:  w = '{op: OP_DAB,  cond: C_MORE_BITS, target: STEP_DAB};
            STEP_SKIP: w = '{op: OP_SKIP, cond: C_SKIP_ZERO, target: STEP_SKIP};
            STEP_EMIT: w = '{op: OP_EMIT, cond: C_NOT_DONE,  target: STEP_EMIT};
            default:   w = '{op: OP_IDLE, cond: C_NO_IN,     target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

### design/bdasc_if.sv
// ----------------------------------------------------------------------------
// bdasc_if
// Valid/ready channels: binary value words in, ASCII character words out.
// ----------------------------------------------------------------------------
interface bdasc_in_if #(
    parameter int VALUE_BITS = bdasc_pkg::DEF_VALUE_BITS
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface bdasc_out_if;
    logic                          valid;
    logic                          ready;
    logic [bdasc_pkg::CHAR_W-1:0]  digit_char;
    logic                          last;

    modport source (output valid, output digit_char, output last, input ready);
    modport sink   (input valid, input digit_char, input last, output ready);
endinterface

### design/bdasc_seq.sv
// ----------------------------------------------------------------------------
// bdasc_seq
// Step counter and control store; picks the next step from datapath status.
// ----------------------------------------------------------------------------
module bdasc_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bdasc_pkg::t_status i_status,
    output bdasc_pkg::t_ctrl   o_ctrl
);
    import bdasc_pkg::*;

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword w_uw;
    logic   w_take;

    assign w_uw      = urom(r_pc);
    assign o_ctrl.op = w_uw.op;

    always_comb begin
        case (w_uw.cond)
            C_NO_IN:     w_take = !i_status.in_fire;
            C_MORE_BITS: w_take = i_status.more_bits;
            C_SKIP_ZERO: w_take = i_status.skip_zero;
            C_NOT_DONE:  w_take = !i_status.emit_last;
            default:     w_take = 1'b0;
        endcase
        n_pc = w_take ? w_uw.target : t_pc'(r_pc + 2'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

### design/bdasc_dp.sv
// ----------------------------------------------------------------------------
// bdasc_dp
// Shift-and-add-3 datapath, leading zero skip and registered character output.
// ----------------------------------------------------------------------------
module bdasc_dp #(
    parameter int VALUE_BITS = bdasc_pkg::DEF_VALUE_BITS,
    parameter int MAX_DIGITS = bdasc_pkg::DEF_MAX_DIGITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bdasc_pkg::t_ctrl   i_ctrl,
    output bdasc_pkg::t_status o_status,
    bdasc_in_if.sink           i_in,
    bdasc_out_if.source        o_out
);
    import bdasc_pkg::*;

    localparam int BCD_W    = 4 * MAX_DIGITS;
    localparam int BITCNT_W = $clog2(VALUE_BITS + 1);
    localparam int DCNT_W   = $clog2(MAX_DIGITS + 1);

    logic [VALUE_BITS-1:0] r_bin,    n_bin;
    logic [BCD_W-1:0]      r_bcd,    n_bcd;
    logic [BITCNT_W-1:0]   r_bitcnt, n_bitcnt;
    logic [DCNT_W-1:0]     r_dcnt,   n_dcnt;
    logic                  r_ovf,    n_ovf;
    logic                  r_ov,     n_ov;
    logic [CHAR_W-1:0]     r_char,   n_char;
    logic                  r_last,   n_last;

    logic [BCD_W-1:0]      w_adj;
    logic [3:0]            w_top;
    logic                  w_in_fire;
    logic                  w_skip_zero;
    logic                  w_emit_ld;

    assign w_top       = r_bcd[BCD_W-1 -: 4];
    assign w_in_fire   = i_in.valid && i_in.ready;
    assign w_skip_zero = (w_top == 4'd0) && (r_dcnt > DCNT_W'(1)) && !r_ovf;
    assign w_emit_ld   = (i_ctrl.op == OP_EMIT) && (!r_ov || o_out.ready);

    assign i_in.ready       = (i_ctrl.op == OP_IDLE);
    assign o_out.valid      = r_ov;
    assign o_out.digit_char = r_char;
    assign o_out.last       = r_last;

    assign o_status.in_fire   = w_in_fire;
    assign o_status.more_bits = (r_bitcnt != BITCNT_W'(1));
    assign o_status.skip_zero = w_skip_zero;
    assign o_status.emit_last = w_emit_ld && (r_dcnt == DCNT_W'(1));

    always_comb begin
        for (int d = 0; d < MAX_DIGITS; d++) begin
            w_adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? 4'(r_bcd[4*d +: 4] + 4'd3)
                                                         : r_bcd[4*d +: 4];
        end
    end

    always_comb begin
        n_bin    = r_bin;
        n_bcd    = r_bcd;
        n_bitcnt = r_bitcnt;
        n_dcnt   = r_dcnt;
        n_ovf    = r_ovf;
        n_char   = r_char;
        n_last   = r_last;
        n_ov     = r_ov && !o_out.ready;
        case (i_ctrl.op)
            OP_IDLE: begin
                if (w_in_fire) begin
                    n_bin    = i_in.value;
                    n_bcd    = '0;
                    n_bitcnt = BITCNT_W'(VALUE_BITS);
                    n_dcnt   = DCNT_W'(MAX_DIGITS);
                    n_ovf    = 1'b0;
                end
            end
            OP_DAB: begin
                n_bcd    = {w_adj[BCD_W-2:0], r_bin[VALUE_BITS-1]};
                n_ovf    = r_ovf | w_adj[BCD_W-1];
                n_bin    = {r_bin[VALUE_BITS-2:0], 1'b0};
                n_bitcnt = r_bitcnt - BITCNT_W'(1);
            end
            OP_SKIP: begin
                if (w_skip_zero) begin
                    n_bcd  = r_bcd << 4;
                    n_dcnt = r_dcnt - DCNT_W'(1);
                end
            end
            OP_EMIT: begin
                if (w_emit_ld) begin
                    n_char = ASCII_ZERO + {2'b00, w_top};
                    n_last = (r_dcnt == DCNT_W'(1));
                    n_ov   = 1'b1;
                    n_bcd  = r_bcd << 4;
                    n_dcnt = r_dcnt - DCNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bitcnt <= '0;
            r_dcnt   <= '0;
            r_ovf    <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_bitcnt <= n_bitcnt;
            r_dcnt   <= n_dcnt;
            r_ovf    <= n_ovf;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_char <= n_char;
        r_last <= n_last;
    end

    a_load_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (r_bitcnt == BITCNT_W'(VALUE_BITS)) && (r_dcnt == DCNT_W'(MAX_DIGITS)))
        else $error("bit counter not loaded");

    a_dab_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_DAB) |-> (r_bitcnt != '0))
        else $error("conversion step with no bits left");

    a_emit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_EMIT) |-> (r_dcnt != '0))
        else $error("emit with no digits left");

    a_char_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_char >= ASCII_ZERO) && (r_char <= ASCII_NINE))
        else $error("character out of digit range");

    a_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> !i_in.ready)
        else $error("input taken while converting");

endmodule

### design/binary_to_decimal_ascii_core.sv
// Sequence: after the value word is taken come VALUE_BITS shift-and-add-3
// steps, one step per suppressed zero, one skip exit step and one output load
// step, which makes the first character word valid.
// Each value word passes the accept, 32 shift, skip exit and MAX_DIGITS skip
// or emit steps, which sink stalls extend; the next word is then accepted.
// Reset: synchronous active-low i_rst_n returns the step counter to idle and
// empties the output register; no clearing pass.
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core
// Converts an unsigned binary value word into its decimal ASCII characters,
// most significant first, leading zeros suppressed, last character marked.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_core #(
    parameter int VALUE_BITS = bdasc_pkg::DEF_VALUE_BITS,
    parameter int MAX_DIGITS = bdasc_pkg::DEF_MAX_DIGITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bdasc_in_if.sink    i_in,
    bdasc_out_if.source o_out
);
    import bdasc_pkg::*;

    t_ctrl   w_ctrl;
    t_status w_status;

    bdasc_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_ctrl   (w_ctrl)
    );

    bdasc_dp #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .o_status (w_status),
        .i_in     (i_in),
        .o_out    (o_out)
    );

endmodule

### tb/sv/tb_binary_to_decimal_ascii_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binary_to_decimal_ascii_core
// Feeds 32-bit value words into the converter and checks every ASCII digit
// word against a scoreboard: a short table of directed values, some with
// their text typed in, then random values of every decimal length, with
// random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_binary_to_decimal_ascii_core;
    import bdasc_pkg::*;

    localparam int VBITS    = DEF_VALUE_BITS;
    localparam int NDIGITS  = DEF_MAX_DIGITS;
    localparam int PLAN_LEN = 20;
    localparam int RAND_LEN = 140;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
    } t_char_word;

    localparam logic [VBITS-1:0] PLAN_VALUE [PLAN_LEN] = '{
        32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd4294967295,
        32'd1000000000, 32'd999999999, 32'd2147483648, 32'd4000000000,
        32'd100000000, 32'd12345, 32'h5555_5555, 32'hAAAA_AAAA,
        32'd1073741824, 32'd3999999999, 32'd65535, 32'd0, 32'd7
    };
    string plan_text [PLAN_LEN] = '{
        "0", "1", "9", "10", "99", "100", "4294967295",
        "1000000000", "999999999", "2147483648", "4000000000",
        "100000000", "", "", "",
        "", "", "", "0", ""
    };
    localparam logic [VBITS-1:0] POW10 [10] = '{
        32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
        32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
    };

    logic       i_clk;
    logic       rst_n;
    logic       calm;
    int         fails;
    t_char_word digit_q [$];
    t_char_word want;

    bdasc_in_if #(.VALUE_BITS(VBITS)) in_if ();
    bdasc_out_if out_if ();

    binary_to_decimal_ascii_core #(
        .VALUE_BITS(VBITS),
        .MAX_DIGITS(NDIGITS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // decimal digits of one value, most significant first
    function automatic void predict_digits(input logic [VBITS-1:0] v);
        logic [3:0]       dig [$];
        logic [VBITS-1:0] rest;
        t_char_word       w;
        rest = v;
        do begin
            dig.push_front(4'(rest % 10));
            rest = rest / 10;
        end while (rest != 0);
        while (dig.size() > NDIGITS) void'(dig.pop_front());
        foreach (dig[k]) begin
            w.digit_char = ASCII_ZERO + CHAR_W'(dig[k]);
            w.last       = (k == dig.size() - 1);
            digit_q.push_back(w);
        end
    endfunction

    function automatic void queue_text(input string s);
        t_char_word w;
        for (int k = 0; k < s.len(); k++) begin
            w.digit_char = CHAR_W'(s[k]);
            w.last       = (k == s.len() - 1);
            digit_q.push_back(w);
        end
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_value(input logic [VBITS-1:0] v, input string text);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            in_if.value <= $urandom;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.value <= v;
        do @(posedge i_clk); while (!in_if.ready);
        if (text.len() > 0) queue_text(text);
        else predict_digits(v);
        @(negedge i_clk);
    endtask

    task automatic drain_words();
        in_if.valid <= 1'b0;
        while (digit_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [VBITS-1:0] random_value();
        logic [VBITS-1:0] v;
        int               nbits;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: begin
                nbits = $urandom_range(1, VBITS);
                v = $urandom;
                if (nbits < VBITS) v = v & ((VBITS'(1) << nbits) - 1);
            end
            2: v = POW10[$urandom_range(0, 9)] + VBITS'($urandom_range(0, 2)) - 1;
            default: v = VBITS'($urandom_range(0, 20));
        endcase
        return v;
    endfunction

    // output side: random stall before each word
    initial begin
        int stall;
        out_if.ready = 1'b0;
        wait (rst_n);
        @(negedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (rst_n && out_if.valid && out_if.ready) begin
            if (digit_q.size() == 0) begin
                $error("unexpected word: digit_char %0d last %0b",
                       out_if.digit_char, out_if.last);
                fails++;
            end else begin
                want = digit_q.pop_front();
                if (out_if.digit_char !== want.digit_char) begin
                    $error("digit_char expected %0d actual %0d",
                           want.digit_char, out_if.digit_char);
                    fails++;
                end
                if (out_if.last !== want.last) begin
                    $error("last expected %0b actual %0b", want.last, out_if.last);
                    fails++;
                end
            end
        end
    end

    initial begin
        rst_n       = 1'b0;
        calm        = 1'b0;
        fails       = 0;
        in_if.valid = 1'b0;
        in_if.value = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < PLAN_LEN; i++) send_value(PLAN_VALUE[i], plan_text[i]);
        drain_words();

        for (int i = 0; i < RAND_LEN; i++) begin
            calm = ((i / 20) % 3 == 2);
            if (i == RAND_LEN / 2) drain_words();
            send_value(random_value(), "");
        end
        calm = 1'b0;
        drain_words();
        repeat (60) @(posedge i_clk);

        if (fails == 0 && digit_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
